[rtl/core/aceenc_pkg.sv]
// Shared types, character constants and helper functions for the ANSI cell escape encoder.
// No dependencies.
`default_nettype none

package aceenc_pkg;

	localparam int DEF_MAX_LINES  = 256;
	localparam int DEF_ATTR_COUNT = 13;
	localparam int ATTR_W         = 13;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  line_number;
		logic [12:0] attr_flags;
		logic        has_attrs;
		logic        has_color;
		logic [7:0]  fg_red;
		logic [7:0]  fg_green;
		logic [7:0]  fg_blue;
		logic [7:0]  bg_red;
		logic [7:0]  bg_green;
		logic [7:0]  bg_blue;
		logic [31:0] glyph_bytes;
	} cell_item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  byte_count;
		logic        last_of_run;
	} word_item_t;

	// decimal string, first character in ch[0], unused characters zero
	typedef struct packed {
		logic [2:0][7:0] ch;
		logic [1:0]      len;
	} dec_t;

	typedef struct packed {
		logic              cmd;
		dec_t              line;
		logic [ATTR_W-1:0] attrs;
		logic              has_color;
		dec_t [2:0]        fg;
		dec_t [2:0]        bg;
		logic [3:0][7:0]   glyph;
		logic [2:0]        glyph_len;
	} desc_t;

	// up to four bytes, first in bytes[0], unused bytes zero
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
		logic            last;
	} tok_t;

	// values up to 999; reciprocal multiplies stand in for /100 and /10
	function automatic dec_t dec_str(input logic [9:0] v);
		logic [15:0] hp;
		logic [3:0]  h;
		logic [9:0]  r100;
		logic [6:0]  rem;
		logic [14:0] tp;
		logic [3:0]  t;
		logic [6:0]  o7;
		logic [7:0]  o;
		dec_t        d;
		hp   = 16'(v) * 16'd41;
		h    = hp[15:12];
		r100 = v - 10'(h) * 10'd100;
		rem  = r100[6:0];
		tp   = 15'(rem) * 15'd205;
		t    = tp[14:11];
		o7   = rem - 7'(t) * 7'd10;
		o    = CH_ZERO + 8'(o7);
		d    = '0;
		if (h != 4'd0) begin
			d.ch[0] = CH_ZERO + 8'(h);
			d.ch[1] = CH_ZERO + 8'(t);
			d.ch[2] = o;
			d.len   = 2'd3;
		end else if (t != 4'd0) begin
			d.ch[0] = CH_ZERO + 8'(t);
			d.ch[1] = o;
			d.len   = 2'd2;
		end else begin
			d.ch[0] = o;
			d.len   = 2'd1;
		end
		return d;
	endfunction

	// ";code" for attribute bit k
	function automatic tok_t sgr_tok(input logic [3:0] k);
		tok_t t;
		t          = '0;
		t.bytes[0] = CH_SEMI;
		case (k) inside
			[4'd0:4'd8]: begin
				t.bytes[1] = CH_ONE + 8'(k);
				t.len      = 3'd2;
			end
			4'd9: begin
				t.bytes[1] = CH_TWO;
				t.bytes[2] = CH_ONE;
				t.len      = 3'd3;
			end
			4'd10: begin
				t.bytes[1] = CH_FIVE;
				t.bytes[2] = CH_THREE;
				t.len      = 3'd3;
			end
			4'd11: begin
				t.bytes[1] = CH_FIVE;
				t.bytes[2] = CH_ONE;
				t.len      = 3'd3;
			end
			4'd12: begin
				t.bytes[1] = CH_FIVE;
				t.bytes[2] = CH_TWO;
				t.len      = 3'd3;
			end
			default: begin
				t = '0;
			end
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

[rtl/core/aceenc_chan_if.sv]
// Valid/ready channel carrying one item of any payload type.
// No dependencies.
`default_nettype none

interface aceenc_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/aceenc_front.sv]
// Front stage: accepts cell and line items, converts numbers to decimal and registers a descriptor.
// Depends on aceenc_pkg and aceenc_chan_if.
`default_nettype none

module aceenc_front
	import aceenc_pkg::*;
#(
	parameter int MAX_LINES  = DEF_MAX_LINES,
	parameter int ATTR_COUNT = DEF_ATTR_COUNT
) (
	input  logic           clk,
	input  logic           arst_n,
	aceenc_chan_if.sink    cell_in,
	aceenc_chan_if.source  desc_out
);

	localparam logic [9:0]        LINE_TOP  = 10'(MAX_LINES - 1);
	localparam logic [ATTR_W-1:0] ATTR_MASK = ATTR_W'((1 << ATTR_COUNT) - 1);

	cell_item_t item;
	desc_t      desc_d;
	desc_t      desc_s1;
	logic       valid_s1;
	logic [9:0] line_c;
	logic       alive;

	assign item = cell_in.payload;

	always_comb begin
		desc_d = '0;
		alive  = 1'b1;
		line_c = ({2'b00, item.line_number} > LINE_TOP) ? LINE_TOP : {2'b00, item.line_number};
		desc_d.cmd       = item.cmd;
		desc_d.line      = dec_str(line_c + 10'd1);
		desc_d.attrs     = item.has_attrs ? (item.attr_flags & ATTR_MASK) : '0;
		desc_d.has_color = item.has_color;
		desc_d.fg[0]     = dec_str({2'b00, item.fg_red});
		desc_d.fg[1]     = dec_str({2'b00, item.fg_green});
		desc_d.fg[2]     = dec_str({2'b00, item.fg_blue});
		desc_d.bg[0]     = dec_str({2'b00, item.bg_red});
		desc_d.bg[1]     = dec_str({2'b00, item.bg_green});
		desc_d.bg[2]     = dec_str({2'b00, item.bg_blue});
		if (item.glyph_bytes[7:0] == 8'd0) begin
			desc_d.glyph[0]  = CH_SPACE;
			desc_d.glyph_len = 3'd1;
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (item.glyph_bytes[8*i +: 8] == 8'd0)
					alive = 1'b0;
				if (alive) begin
					desc_d.glyph[i]  = item.glyph_bytes[8*i +: 8];
					desc_d.glyph_len = 3'(i + 1);
				end
			end
		end
	end

	assign cell_in.ready    = !valid_s1 || desc_out.ready;
	assign desc_out.valid   = valid_s1;
	assign desc_out.payload = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_in.ready) begin
			valid_s1 <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_in.valid && cell_in.ready) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/aceenc_queue.sv]
// Two-entry descriptor queue between the front and back stages.
// Depends on aceenc_pkg and aceenc_chan_if.
`default_nettype none

module aceenc_queue
	import aceenc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	aceenc_chan_if.sink    src,
	aceenc_chan_if.source  dst
);

	localparam logic [1:0] DEPTH = 2'd2;

	desc_t      slot_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic       pop;

	assign src.ready   = (count_q != DEPTH);
	assign dst.valid   = (count_q != 2'd0);
	assign dst.payload = slot_q[rd_ptr_q];
	assign push        = src.valid && src.ready;
	assign pop         = dst.valid && dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= src.payload;
		end
	end

endmodule

`default_nettype wire

[rtl/core/aceenc_back.sv]
// Back stage: walks a descriptor one token per cycle when not stalled and packs the bytes, up to four to a word.
// Depends on aceenc_pkg and aceenc_chan_if.
`default_nettype none

module aceenc_back
	import aceenc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	aceenc_chan_if.sink    desc_in,
	aceenc_chan_if.source  word_out
);

	localparam logic [3:0] S_HEAD  = 4'd0;
	localparam logic [3:0] S_LINE  = 4'd1;
	localparam logic [3:0] S_LTAIL = 4'd2;
	localparam logic [3:0] S_ATTR  = 4'd3;
	localparam logic [3:0] S_CSEL  = 4'd4;
	localparam logic [3:0] S_CTWO  = 4'd5;
	localparam logic [3:0] S_CR    = 4'd6;
	localparam logic [3:0] S_CG    = 4'd7;
	localparam logic [3:0] S_CB    = 4'd8;
	localparam logic [3:0] S_M     = 4'd9;
	localparam logic [3:0] S_GLYPH = 4'd10;

	desc_t             d;
	tok_t              tok;
	logic [3:0]        state_q, state_d;
	logic [ATTR_W-1:0] mask_q, mask_d, mask_rest;
	logic              sel_q, sel_d;
	logic [3:0]        low_k;
	dec_t [2:0]        col;
	logic              adv, take;

	logic [2:0][7:0]   res_q, res_d, res_m;
	logic [1:0]        rcnt_q, rcnt_d;
	logic              flush_q, flush_d;
	logic [2:0]        fill;
	logic [6:0][7:0]   comb;
	logic              emit;
	word_item_t        word_d;
	word_item_t        out_q;
	logic              out_v_q;

	assign d = desc_in.payload;

	always_comb begin
		low_k = 4'd0;
		for (int i = ATTR_W - 1; i >= 0; i--) begin
			if (mask_q[i])
				low_k = 4'(i);
		end
	end

	assign mask_rest = mask_q & (mask_q - ATTR_W'(1));
	assign col       = sel_q ? d.bg : d.fg;

	always_comb begin
		tok     = '0;
		state_d = state_q;
		mask_d  = mask_q;
		sel_d   = sel_q;
		case (state_q)
			S_HEAD: begin
				tok.bytes[0] = CH_ESC;
				tok.bytes[1] = CH_LBR;
				sel_d        = 1'b0;
				mask_d       = d.attrs;
				if (!d.cmd) begin
					tok.len = 3'd2;
					state_d = S_LINE;
				end else begin
					tok.bytes[2] = CH_ZERO;
					tok.len      = 3'd3;
					if (d.attrs != '0)
						state_d = S_ATTR;
					else if (d.has_color)
						state_d = S_CSEL;
					else
						state_d = S_M;
				end
			end
			S_LINE: begin
				tok.bytes = {8'd0, d.line.ch};
				tok.len   = {1'b0, d.line.len};
				state_d   = S_LTAIL;
			end
			S_LTAIL: begin
				tok.bytes = {8'd0, CH_H, CH_ONE, CH_SEMI};
				tok.len   = 3'd3;
				tok.last  = 1'b1;
				state_d   = S_HEAD;
			end
			S_ATTR: begin
				tok    = sgr_tok(low_k);
				mask_d = mask_rest;
				if (mask_rest != '0)
					state_d = S_ATTR;
				else if (d.has_color)
					state_d = S_CSEL;
				else
					state_d = S_M;
			end
			S_CSEL: begin
				tok.bytes = {CH_SEMI, CH_EIGHT, (sel_q ? CH_FOUR : CH_THREE), CH_SEMI};
				tok.len   = 3'd4;
				state_d   = S_CTWO;
			end
			S_CTWO: begin
				tok.bytes = {16'd0, CH_SEMI, CH_TWO};
				tok.len   = 3'd2;
				state_d   = S_CR;
			end
			S_CR: begin
				tok.bytes = {8'd0, col[0].ch};
				tok.len   = {1'b0, col[0].len};
				state_d   = S_CG;
			end
			S_CG: begin
				tok.bytes = {col[1].ch, CH_SEMI};
				tok.len   = {1'b0, col[1].len} + 3'd1;
				state_d   = S_CB;
			end
			S_CB: begin
				tok.bytes = {col[2].ch, CH_SEMI};
				tok.len   = {1'b0, col[2].len} + 3'd1;
				sel_d     = 1'b1;
				state_d   = sel_q ? S_M : S_CSEL;
			end
			S_M: begin
				tok.bytes[0] = CH_M;
				tok.len      = 3'd1;
				state_d      = S_GLYPH;
			end
			S_GLYPH: begin
				tok.bytes = d.glyph;
				tok.len   = d.glyph_len;
				tok.last  = 1'b1;
				state_d   = S_HEAD;
			end
			default: begin
				state_d = S_HEAD;
			end
		endcase
	end

	assign adv           = !out_v_q || word_out.ready;
	assign take          = adv && !flush_q && desc_in.valid;
	assign desc_in.ready = take && tok.last;

	// byte packer: residue of up to three bytes carried between tokens
	always_comb begin
		for (int i = 0; i < 3; i++)
			res_m[i] = (2'(i) < rcnt_q) ? res_q[i] : 8'd0;
		fill    = {1'b0, rcnt_q} + tok.len;
		comb    = {32'd0, res_m} | ({24'd0, tok.bytes} << {rcnt_q, 3'b000});
		emit    = 1'b0;
		word_d  = '0;
		res_d   = res_q;
		rcnt_d  = rcnt_q;
		flush_d = flush_q;
		if (flush_q) begin
			emit               = 1'b1;
			word_d.out_word    = {8'd0, res_m};
			word_d.byte_count  = {1'b0, rcnt_q};
			word_d.last_of_run = 1'b1;
			rcnt_d             = 2'd0;
			flush_d            = 1'b0;
		end else if (desc_in.valid) begin
			if (fill >= 3'd4) begin
				emit               = 1'b1;
				word_d.out_word    = comb[3:0];
				word_d.byte_count  = 3'd4;
				word_d.last_of_run = tok.last && (fill == 3'd4);
				res_d              = comb[6:4];
				rcnt_d             = 2'(fill - 3'd4);
				flush_d            = tok.last && (fill != 3'd4);
			end else if (tok.last) begin
				emit               = 1'b1;
				word_d.out_word    = comb[3:0];
				word_d.byte_count  = fill;
				word_d.last_of_run = 1'b1;
				rcnt_d             = 2'd0;
			end else begin
				res_d  = comb[2:0];
				rcnt_d = fill[1:0];
			end
		end
	end

	assign word_out.valid   = out_v_q;
	assign word_out.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HEAD;
			mask_q  <= '0;
			sel_q   <= 1'b0;
			rcnt_q  <= 2'd0;
			flush_q <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= emit;
			rcnt_q  <= rcnt_d;
			flush_q <= flush_d;
			if (take) begin
				state_q <= state_d;
				mask_q  <= mask_d;
				sel_q   <= sel_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
			if (emit)
				out_q <= word_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/ansi_cell_escape_encoder_top.sv]
// Latency: an item passes the front register and the queue before the back stage walks it.
// Throughput: one token per cycle while the output does not stall; a line item takes 3 tokens,
// a cell item 13 + (set attribute bits) tokens with color, 3 + (set attribute bits) without,
// plus a flush step after a last full word with bytes left over. The token walk sets the pace.
// Reset: arst_n clears all valid flags, the queue and the sequencer; no clearing pass.
// Depends on aceenc_pkg, aceenc_chan_if, aceenc_front, aceenc_queue and aceenc_back.
`default_nettype none

module ansi_cell_escape_encoder_top
	import aceenc_pkg::*;
#(
	parameter int MAX_LINES  = DEF_MAX_LINES,
	parameter int ATTR_COUNT = DEF_ATTR_COUNT
) (
	input  logic           clk,
	input  logic           arst_n,
	aceenc_chan_if.sink    cell_in,
	aceenc_chan_if.source  word_out
);

	aceenc_chan_if #(.payload_t(desc_t)) f2q ();
	aceenc_chan_if #(.payload_t(desc_t)) q2b ();

	aceenc_front #(
		.MAX_LINES  (MAX_LINES),
		.ATTR_COUNT (ATTR_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_in  (cell_in),
		.desc_out (f2q)
	);

	aceenc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (f2q),
		.dst    (q2b)
	);

	aceenc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.desc_in  (q2b),
		.word_out (word_out)
	);

endmodule

`default_nettype wire

[verif/tb_ansi_cell_escape_encoder_top.sv]
// Self-checking testbench for ansi_cell_escape_encoder_top: drives cell and line items and
// checks every packed escape word against a byte-level encoder model kept in a scoreboard.
// Depends on aceenc_pkg, aceenc_chan_if and the RTL under rtl/core.

module tb_ansi_cell_escape_encoder_top;
	import aceenc_pkg::*;

	localparam logic CMD_LINE = 1'b0;
	localparam logic CMD_CELL = 1'b1;

	localparam int LINE_LIMIT   = DEF_MAX_LINES;
	localparam int RANDOM_ITEMS = 250;
	localparam int HOLD_START   = 60;
	localparam int HOLD_ITEMS   = 40;
	localparam int QUIET_ITEMS  = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SHOWN_ERRORS = 10;

	class escape_scoreboard;
		word_item_t  expected_words[$];
		logic [7:0]  esc_bytes[$];
		int unsigned mismatches;
		int unsigned sgr_code[13] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 21, 53, 51, 52};

		function void append_dec(int unsigned v);
			if (v >= 100)
				esc_bytes.push_back(CH_ZERO + 8'(v / 100));
			if (v >= 10)
				esc_bytes.push_back(CH_ZERO + 8'((v / 10) % 10));
			esc_bytes.push_back(CH_ZERO + 8'(v % 10));
		endfunction

		function void append_rgb(int unsigned sel, logic [23:0] rgb);
			esc_bytes.push_back(CH_SEMI);
			append_dec(sel);
			esc_bytes.push_back(CH_SEMI);
			esc_bytes.push_back(CH_TWO);
			esc_bytes.push_back(CH_SEMI);
			append_dec(32'(rgb[23:16]));
			esc_bytes.push_back(CH_SEMI);
			append_dec(32'(rgb[15:8]));
			esc_bytes.push_back(CH_SEMI);
			append_dec(32'(rgb[7:0]));
		endfunction

		// builds the escape byte stream of one item and queues its packed words
		function void note_cell(cell_item_t c);
			int unsigned line;
			int unsigned cnt;
			int          k;
			int          pos;
			word_item_t  w;
			esc_bytes.delete();
			esc_bytes.push_back(CH_ESC);
			esc_bytes.push_back(CH_LBR);
			if (c.cmd == CMD_LINE) begin
				line = 32'(c.line_number);
				if (line >= LINE_LIMIT)
					line = LINE_LIMIT - 1;
				append_dec(line + 1);
				esc_bytes.push_back(CH_SEMI);
				esc_bytes.push_back(CH_ONE);
				esc_bytes.push_back(CH_H);
			end else begin
				esc_bytes.push_back(CH_ZERO);
				if (c.has_attrs) begin
					for (k = 0; k < DEF_ATTR_COUNT; k++) begin
						if (c.attr_flags[k]) begin
							esc_bytes.push_back(CH_SEMI);
							append_dec(sgr_code[k]);
						end
					end
				end
				if (c.has_color) begin
					append_rgb(38, {c.fg_red, c.fg_green, c.fg_blue});
					append_rgb(48, {c.bg_red, c.bg_green, c.bg_blue});
				end
				esc_bytes.push_back(CH_M);
				if (c.glyph_bytes[7:0] == 8'h00)
					esc_bytes.push_back(CH_SPACE);
				else
					for (k = 0; k < 4 && c.glyph_bytes[8*k +: 8] != 8'h00; k++)
						esc_bytes.push_back(c.glyph_bytes[8*k +: 8]);
			end
			for (pos = 0; pos < esc_bytes.size(); pos += 4) begin
				cnt = esc_bytes.size() - pos;
				if (cnt > 4)
					cnt = 4;
				w = '0;
				for (k = 0; k < cnt; k++)
					w.out_word[8*k +: 8] = esc_bytes[pos + k];
				w.byte_count  = 3'(cnt);
				w.last_of_run = (pos + 4 >= esc_bytes.size());
				expected_words.push_back(w);
			end
		endfunction

		function void check_word(word_item_t got);
			word_item_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected word %h count %0d last %0b",
						got.out_word, got.byte_count, got.last_of_run);
			end else begin
				want = expected_words.pop_front();
				if (got.out_word !== want.out_word || got.byte_count !== want.byte_count ||
						got.last_of_run !== want.last_of_run) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("word mismatch: expected %h count %0d last %0b, got %h count %0d last %0b",
							want.out_word, want.byte_count, want.last_of_run,
							got.out_word, got.byte_count, got.last_of_run);
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   hold_req;
	bit   holding;
	bit   quiet;
	int unsigned cycle_count;
	escape_scoreboard board;

	aceenc_chan_if #(.payload_t(cell_item_t)) cell_if ();
	aceenc_chan_if #(.payload_t(word_item_t)) word_if ();

	ansi_cell_escape_encoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cell_in (cell_if),
		.word_out(word_if)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] rand_level();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 9));
			1: return 8'($urandom_range(10, 99));
			2: return 8'($urandom_range(100, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_glyph();
		logic [31:0] g;
		int          k;
		g = $urandom;
		k = $urandom_range(0, 3);
		case ($urandom_range(0, 4))
			0: g = '0;
			1: g = {24'h0, g[7:0]};
			2: g[8*k +: 8] = 8'h00;
			default: ;
		endcase
		return g;
	endfunction

	function automatic cell_item_t rand_cell();
		cell_item_t c;
		c.cmd         = ($urandom_range(0, 4) == 0) ? CMD_LINE : CMD_CELL;
		c.line_number = 8'($urandom);
		c.attr_flags  = 13'($urandom);
		c.has_attrs   = 1'($urandom);
		c.has_color   = 1'($urandom);
		c.fg_red      = rand_level();
		c.fg_green    = rand_level();
		c.fg_blue     = rand_level();
		c.bg_red      = rand_level();
		c.bg_green    = rand_level();
		c.bg_blue     = rand_level();
		c.glyph_bytes = rand_glyph();
		return c;
	endfunction

	function automatic cell_item_t make_line(logic [7:0] line);
		cell_item_t c;
		c             = rand_cell();
		c.cmd         = CMD_LINE;
		c.line_number = line;
		return c;
	endfunction

	function automatic cell_item_t make_cell(logic [12:0] attrs, logic use_attrs,
			logic use_color, logic [23:0] fg, logic [23:0] bg, logic [31:0] glyph);
		cell_item_t c;
		c             = rand_cell();
		c.cmd         = CMD_CELL;
		c.attr_flags  = attrs;
		c.has_attrs   = use_attrs;
		c.has_color   = use_color;
		{c.fg_red, c.fg_green, c.fg_blue} = fg;
		{c.bg_red, c.bg_green, c.bg_blue} = bg;
		c.glyph_bytes = glyph;
		return c;
	endfunction

	task automatic offer_cell(input cell_item_t c, input bit allow_gap);
		cell_if.valid   <= 1'b1;
		cell_if.payload <= c;
		@(posedge clk);
		while (!cell_if.ready)
			@(posedge clk);
		board.note_cell(c);
		if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
			cell_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		cell_if.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && word_if.valid && word_if.ready)
			board.check_word(word_if.payload);
	end

	initial begin : receiver
		word_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				word_if.ready <= 1'b0;
				holding = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holding  = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				word_if.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(30, 80)) @(posedge clk);
				else
					repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				word_if.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int n;
		board           = new();
		cell_if.valid   = 1'b0;
		cell_if.payload = '0;
		hold_req        = 1'b0;
		holding         = 1'b0;
		quiet           = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_cell(make_line(8'd0), 1);
		offer_cell(make_line(8'd255), 1);
		offer_cell(make_line(8'd8), 1);
		offer_cell(make_line(8'd9), 1);
		offer_cell(make_line(8'd98), 1);
		offer_cell(make_line(8'd99), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 32'h0000_0000), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 32'h0000_0041), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 32'hFFFF_FFFF), 1);
		// zero byte in the middle cuts the glyph short
		offer_cell(make_cell(13'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 32'h4100_4242), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 32'h4142_4300), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b0, 24'h0, 24'h0, 32'h8098_9FF0), 1);
		offer_cell(make_cell(13'h1FFF, 1'b1, 1'b0, 24'h0, 24'h0, 32'h0000_0058), 1);
		offer_cell(make_cell(13'h1FFF, 1'b0, 1'b0, 24'h0, 24'h0, 32'h0000_0058), 1);
		offer_cell(make_cell(13'h1200, 1'b1, 1'b0, 24'h0, 24'h0, 32'h0000_0023), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'h0000_0040), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b1, 24'h000000, 24'h000000, 32'h0000_0000), 1);
		offer_cell(make_cell(13'h0000, 1'b0, 1'b1, 24'h090A63, 24'h64FE01, 32'h0000_007E), 1);
		offer_cell(make_cell(13'h1FFF, 1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF), 1);
		offer_cell(make_cell(13'h1555, 1'b1, 1'b1, 24'h123456, 24'hABCDEF, 32'h00A9_C2E2), 1);
		offer_cell(make_cell(13'h0AAA, 1'b1, 1'b0, 24'h0, 24'h0, 32'h0000_0061), 1);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_START) begin
				cell_if.valid <= 1'b0;
				hold_req = 1'b1;
				while (!holding)
					@(posedge clk);
			end
			if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
				wait_drained();
				quiet = 1'b1;
			end
			offer_cell(rand_cell(), !(n >= HOLD_START && n < HOLD_START + HOLD_ITEMS));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[ansi_cell_escape_encoder_top.f]
rtl/core/aceenc_pkg.sv
rtl/core/aceenc_chan_if.sv
rtl/core/aceenc_front.sv
rtl/core/aceenc_queue.sv
rtl/core/aceenc_back.sv
rtl/core/ansi_cell_escape_encoder_top.sv
verif/tb_ansi_cell_escape_encoder_top.sv
